[sv/iagpe_pkg.sv]
// ----------------------------------------------------------------------------
// IMA ADPCM gain/pack encoder package
// Step size table, index adjustment and shared widths.
// ----------------------------------------------------------------------------
package iagpe_pkg;

  localparam int unsigned STEP_TOP = 88;

  typedef logic [6:0]         step_idx_t;
  typedef logic [14:0]        step_t;
  typedef logic signed [15:0] pcm_t;
  typedef logic [3:0]         code_t;
  typedef logic signed [4:0]  idx_adj_t;

  localparam step_t STEP_SIZES [0:STEP_TOP] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // Indexes past the top read the top entry.
  function automatic step_t step_size(input step_idx_t idx);
    step_t s;
    if (idx > step_idx_t'(STEP_TOP)) begin
      s = STEP_SIZES[STEP_TOP];
    end else begin
      s = STEP_SIZES[idx];
    end
    return s;
  endfunction

  // -1 for magnitudes 0..3, then 2, 4, 6, 8.
  function automatic idx_adj_t index_adjust(input logic [2:0] mag);
    idx_adj_t a;
    if (mag[2]) begin
      a = idx_adj_t'({2'b00, mag[1:0], 1'b0} + 5'd2);
    end else begin
      a = -5'sd1;
    end
    return a;
  endfunction

endpackage

[sv/ima_adpcm_gain_pack_encoder.sv]
// ----------------------------------------------------------------------------
// IMA ADPCM gain/pack encoder
// Saturating shift gain, 4-bit IMA ADPCM encode, two codes packed per byte.
// ----------------------------------------------------------------------------
// Path: gain into the input register, encode into the result register.
// Throughput: one sample per cycle unless the result register is full and
//   stalled, one byte every second sample; the predictor and step index loop
//   closes within the encode cycle.
// Reset: predictor, step index and pairing clear to zero, gain_shift to 2.
module ima_adpcm_gain_pack_encoder
  import iagpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [15:0] sample,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] packed_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  logic [2:0] gain_shift;

  // Input stage: gained sample
  logic       q_valid;
  pcm_t       q_sample;

  // Encoder state
  pcm_t       predicted_value;
  step_idx_t  step_position;
  code_t      held_code;
  logic       second_half;

  logic       advance;
  logic       accept;

  // Gain
  logic signed [23:0] gained_wide;
  pcm_t               gained;

  // Encode
  step_t              step;
  logic signed [16:0] diff;
  logic               sign;
  logic [15:0]        d0, d1, d2;
  logic [15:0]        step_full, step_half, step_quarter;
  logic [2:0]         mag;
  logic [15:0]        vpdiff;
  logic signed [17:0] pred_wide;
  pcm_t               pred_next;
  logic signed [7:0]  idx_wide;
  step_idx_t          idx_next;
  code_t              code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_shift <= 3'd2;
    end else if (cfg_valid && cfg_ready) begin
      gain_shift <= cfg_data;
    end
  end

  // Shift at 24 bits, then saturate to 16.
  always_comb begin
    gained_wide = 24'(signed'(sample)) <<< gain_shift;
    if (gained_wide > 24'sd32767) begin
      gained = 16'sh7FFF;
    end else if (gained_wide < -24'sd32768) begin
      gained = 16'sh8000;
    end else begin
      gained = gained_wide[15:0];
    end
  end

  // Stall while the second sample of a pair waits on a full, stalled output.
  assign advance  = q_valid && (!second_half || !out_valid || !out_stall);
  assign in_stall = q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_sample <= gained;
    end
  end

  always_comb begin
    step         = step_size(step_position);
    step_full    = {1'b0, step};
    step_half    = {2'b00, step[14:1]};
    step_quarter = {3'b000, step[14:2]};

    diff = 17'(q_sample) - 17'(predicted_value);
    sign = diff[16];
    d0   = sign ? 16'(-diff) : diff[15:0];

    mag[2] = d0 >= step_full;
    d1     = mag[2] ? d0 - step_full : d0;
    mag[1] = d1 >= step_half;
    d2     = mag[1] ? d1 - step_half : d1;
    mag[0] = d2 >= step_quarter;

    vpdiff = {4'b0000, step[14:3]}
           + (mag[2] ? step_full    : 16'd0)
           + (mag[1] ? step_half    : 16'd0)
           + (mag[0] ? step_quarter : 16'd0);

    // Full-width predictor update, clamp without wraparound.
    if (sign) begin
      pred_wide = 18'(predicted_value) - signed'({2'b00, vpdiff});
    end else begin
      pred_wide = 18'(predicted_value) + signed'({2'b00, vpdiff});
    end
    if (pred_wide > 18'sd32767) begin
      pred_next = 16'sh7FFF;
    end else if (pred_wide < -18'sd32768) begin
      pred_next = 16'sh8000;
    end else begin
      pred_next = pred_wide[15:0];
    end

    idx_wide = signed'({1'b0, step_position}) + 8'(index_adjust(mag));
    if (idx_wide < 8'sd0) begin
      idx_next = '0;
    end else if (idx_wide > signed'(8'(STEP_TOP))) begin
      idx_next = step_idx_t'(STEP_TOP);
    end else begin
      idx_next = idx_wide[6:0];
    end

    code = {sign, mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      predicted_value <= '0;
      step_position   <= '0;
      held_code       <= '0;
      second_half     <= 1'b0;
    end else if (advance) begin
      predicted_value <= pred_next;
      step_position   <= idx_next;
      second_half     <= !second_half;
      if (!second_half) begin
        held_code <= code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && second_half) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && second_half) begin
      packed_byte <= {held_code, code};
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMA ADPCM gain/pack encoder testbench
// Drives audio samples through the encoder at several gain settings with
// random idling on both sides. Every packed byte is checked against an
// in-bench encoder that tracks gain, predictor, step index and pairing.
// ----------------------------------------------------------------------------
module testbench
  import iagpe_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;

  class adpcm_scoreboard;
    logic [2:0] gain;
    pcm_t       predictor;
    step_idx_t  step_pos;
    code_t      held_code;
    bit         second_half;
    logic [7:0] expected_bytes[$];
    int         errors;
    int         adjust[8];

    function new();
      gain        = 3'd2;
      predictor   = '0;
      step_pos    = '0;
      held_code   = '0;
      second_half = 1'b0;
      errors      = 0;
      adjust      = '{-1, -1, -1, -1, 2, 4, 6, 8};
    endfunction

    function void set_gain(input logic [2:0] g);
      gain = g;
    endfunction

    function int clamp16(input int v);
      int r;
      r = v;
      if (v > 32767) begin
        r = 32767;
      end else if (v < -32768) begin
        r = -32768;
      end
      return r;
    endfunction

    // Gain, encode one code, advance predictor and step index, pair codes.
    function void note_sample(input logic [15:0] raw);
      int         scaled;
      int         diff;
      int         step;
      int         delta;
      int         next_pos;
      logic [2:0] mag;
      logic       neg;
      code_t      code;
      scaled = clamp16(int'(pcm_t'(raw)) * (1 << gain));
      diff   = scaled - int'(predictor);
      step   = int'(STEP_SIZES[step_pos]);
      delta  = step >> 3;
      mag    = 3'd0;
      neg    = 1'b0;
      if (diff < 0) begin
        neg  = 1'b1;
        diff = -diff;
      end
      if (diff >= step) begin
        mag[2] = 1'b1;
        diff   = diff - step;
        delta  = delta + step;
      end
      step = step >> 1;
      if (diff >= step) begin
        mag[1] = 1'b1;
        diff   = diff - step;
        delta  = delta + step;
      end
      step = step >> 1;
      if (diff >= step) begin
        mag[0] = 1'b1;
        delta  = delta + step;
      end
      predictor = pcm_t'(clamp16(neg ? int'(predictor) - delta : int'(predictor) + delta));
      next_pos = int'(step_pos) + adjust[mag];
      if (next_pos < 0) begin
        next_pos = 0;
      end else if (next_pos > STEP_TOP) begin
        next_pos = STEP_TOP;
      end
      step_pos = step_idx_t'(next_pos);
      code     = {neg, mag};
      if (!second_half) begin
        held_code   = code;
        second_half = 1'b1;
      end else begin
        expected_bytes.push_back({held_code, code});
        second_half = 1'b0;
      end
    endfunction

    task report_mismatch(input string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    task check_byte(input logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", got));
      end else begin
        want = expected_bytes.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("packed_byte got %02h expected %02h", got, want));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] sample = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  packed_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = 3'd0;

  adpcm_scoreboard sb;
  bit quiet = 1'b0;
  int cycles = 0;
  int wave_pos = 0;
  int wave_inc = 100;
  int wave_amp = 20000;

  ima_adpcm_gain_pack_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .packed_byte (packed_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Observe requests and results with pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sb.set_gain(cfg_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_sample(sample);
      end
      if (out_valid && !out_stall) begin
        sb.check_byte(packed_byte);
      end
    end
  end

  // Receiver back-pressure in bursts; none once quiet is set.
  initial begin : stall_gen
    int  n;
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 18);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic drive_sample(input logic [15:0] value, input bit allow_gap);
    int k;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain, let the last unpaired sample settle, then write the gain.
  task automatic write_gain(input logic [2:0] g);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly smooth waveforms, with bursts of noise, rails and near-silence.
  task automatic random_phase(input int count, input bit allow_gap);
    int          run;
    int          kind;
    int          v;
    logic [15:0] value;
    run  = 0;
    kind = 0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        run  = $urandom_range(4, 40);
        v    = $urandom_range(0, 9);
        kind = (v < 6) ? 0 : (v < 8) ? 1 : (v < 9) ? 2 : 3;
        wave_inc = $urandom_range(1, 4000);
        wave_amp = $urandom_range(100, 32000);
      end
      run--;
      case (kind)
        0: begin
          wave_pos = wave_pos + wave_inc;
          if (wave_pos > wave_amp || wave_pos < -wave_amp) begin
            wave_inc = -wave_inc;
            wave_pos = wave_pos + 2 * wave_inc;
          end
          v = wave_pos + $urandom_range(0, 63) - 32;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          value = v[15:0];
        end
        1: begin
          value = 16'($urandom_range(0, 65535));
        end
        2: begin
          v = $urandom_range(0, 3);
          value = (v == 0) ? 16'h7fff : (v == 1) ? 16'h8000 : (v == 2) ? 16'h0000 : 16'hffff;
        end
        default: begin
          v = $urandom_range(0, 127) - 64;
          value = v[15:0];
        end
      endcase
      drive_sample(value, allow_gap);
    end
  endtask

  initial begin : main
    logic [15:0] directed[$];
    logic [2:0]  gains[8];
    sb = new();
    gains = '{3'd0, 3'd7, 3'd4, 3'd1, 3'd5, 3'd3, 3'd6, 3'd2};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Hold at the index floor, ramp to the top with full-scale input, then swing
    // to the negative rail so the predictor clamps on both sides.
    directed = '{16'h0000, 16'h0000, 16'h0001, 16'hffff};
    repeat (12) directed.push_back(16'h7fff);
    repeat (6) directed.push_back(16'h8000);
    directed.push_back(16'h7fff);
    directed.push_back(16'h0000);
    directed.push_back(16'h8000);
    foreach (directed[i]) drive_sample(directed[i], 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_gain(gains[p]);
      if (p == 7) begin
        quiet = 1'b1;
      end
      random_phase(95, p != 7);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.expected_bytes.size() != 0) begin
      sb.report_mismatch("bytes still expected at end of run");
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[ima_adpcm_gain_pack_encoder.f]
sv/iagpe_pkg.sv
sv/ima_adpcm_gain_pack_encoder.sv
tb/sv/testbench.sv
